// ===== hdl/pfrr_pkg.sv =====
// ----------------------------------------------------------------------------
// pfrr_pkg
// Shared types for the partition fair round-robin scheduler: slot status
// codes, request codes, slot table entry, compare flags and sequencer states.
// ----------------------------------------------------------------------------
package pfrr_pkg;

  localparam int PartFieldW  = 3;
  localparam int StatusW     = 2;
  localparam int ReqW        = 2;
  localparam int SlotFieldW  = 4;
  localparam int KillCountW  = 5;
  localparam int PauseW      = 8;

  typedef enum logic [StatusW-1:0] {
    ST_FREE          = 2'd0,
    ST_RUNNING       = 2'd1,
    ST_SUSPENDED     = 2'd2,
    ST_ENTRY_PENDING = 2'd3
  } slot_status_e;

  typedef enum logic [ReqW-1:0] {
    REQ_TICK  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_KILL  = 2'd2
  } req_e;

  typedef struct packed {
    slot_status_e          status;
    logic [PartFieldW-1:0] part;
  } slot_entry_t;

  // Flags from the shared compare unit for the slot under the scan pointer.
  typedef struct packed {
    logic running;
    logic suspended;
    logic occupied;
    logic part_eq;
    logic candidate;
  } match_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RUN,
    S_PICK_PART,
    S_SCAN_SLOT,
    S_SWAP_CUR,
    S_SWAP_NEXT,
    S_KILL,
    S_DONE
  } sched_state_e;

endpackage

// ===== hdl/pfrr_slot_table.sv =====
// ----------------------------------------------------------------------------
// pfrr_slot_table
// Slot status and partition table. One read port at the scan pointer, one
// write port shared by slot writes, kills and context swaps.
// ----------------------------------------------------------------------------
module pfrr_slot_table #(
  parameter int SLOTS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [$clog2(SLOTS)-1:0]   rd_idx_i,
  output pfrr_pkg::slot_entry_t      rd_entry_o,
  input  logic                       wr_en_i,
  input  logic [$clog2(SLOTS)-1:0]   wr_idx_i,
  input  pfrr_pkg::slot_entry_t      wr_entry_i
);
  import pfrr_pkg::*;

  slot_entry_t table_q [SLOTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        table_q[i] <= '{status: ST_FREE, part: '0};
      end
    end else if (wr_en_i) begin
      table_q[wr_idx_i] <= wr_entry_i;
    end
  end

  assign rd_entry_o = table_q[rd_idx_i];

endmodule

// ===== hdl/pfrr_match_unit.sv =====
// ----------------------------------------------------------------------------
// pfrr_match_unit
// Shared compare unit: classifies one slot entry against a target partition
// and an excluded slot, and steps the scan pointer with wraparound.
// ----------------------------------------------------------------------------
module pfrr_match_unit #(
  parameter int SLOTS = 16
) (
  input  pfrr_pkg::slot_entry_t                entry_i,
  input  logic [pfrr_pkg::PartFieldW-1:0]      target_part_i,
  input  logic [$clog2(SLOTS)-1:0]             idx_i,
  input  logic [$clog2(SLOTS)-1:0]             exclude_idx_i,
  output pfrr_pkg::match_t                     match_o,
  output logic [$clog2(SLOTS)-1:0]             step_idx_o
);
  import pfrr_pkg::*;

  localparam int SlotW = $clog2(SLOTS);

  always_comb begin
    match_o.running   = (entry_i.status == ST_RUNNING);
    match_o.suspended = (entry_i.status == ST_SUSPENDED);
    match_o.occupied  = (entry_i.status != ST_FREE);
    match_o.part_eq   = (entry_i.part == target_part_i);
    match_o.candidate = match_o.suspended && match_o.part_eq && (idx_i != exclude_idx_i);
  end

  assign step_idx_o = (idx_i == SlotW'(SLOTS - 1)) ? '0 : idx_i + SlotW'(1);

endmodule

// ===== hdl/partition_fair_round_robin_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// partition_fair_round_robin_scheduler_unit
// Two-level round-robin scheduler: picks a partition, then a slot in it.
// ----------------------------------------------------------------------------
// Items are taken one at a time; in_stall_o is high from acceptance until the
// result has moved into the output register. A tick walks the slot table
// three ways through one compare unit and one table read port: a pass over
// all SLOTS slots to find the lowest running slot and mark which partitions
// hold suspended slots, a walk of up to PARTITIONS partitions from the last
// scheduled one, and a walk of up to SLOTS slots from that partition's cursor.
// A switch then rewrites the preempted and then the chosen slot through the
// single write port. A tick with no running slot ends after the first pass; a
// kill makes one pass over all slots. The next item is accepted while the last
// result waits downstream.
// ----------------------------------------------------------------------------
module partition_fair_round_robin_scheduler_unit #(
  parameter int SLOTS      = 16,
  parameter int PARTITIONS = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration: pause mask
  input  logic                                 cfg_we_i,
  input  logic [pfrr_pkg::PauseW-1:0]          cfg_wdata_i,
  // request channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [pfrr_pkg::ReqW-1:0]            req_type_i,
  input  logic [pfrr_pkg::SlotFieldW-1:0]      slot_index_i,
  input  logic [pfrr_pkg::StatusW-1:0]         slot_status_i,
  input  logic [pfrr_pkg::PartFieldW-1:0]      partition_i,
  // result channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 had_current_o,
  output logic                                 switched_o,
  output logic [pfrr_pkg::SlotFieldW-1:0]      running_slot_o,
  output logic [pfrr_pkg::KillCountW-1:0]      killed_count_o
);
  import pfrr_pkg::*;

  localparam int SlotW  = $clog2(SLOTS);
  localparam int PartW  = $clog2(PARTITIONS);
  localparam int CntMax = (SLOTS > PARTITIONS) ? SLOTS : PARTITIONS;
  localparam int CntW   = $clog2(CntMax);

  sched_state_e state_q, state_d;

  logic [PauseW-1:0]     pause_q;
  logic [SlotW-1:0]      idx_q, idx_d;        // table scan pointer
  logic [CntW-1:0]       cnt_q, cnt_d;        // steps taken in a walk
  logic                  cur_found_q, cur_found_d;
  logic [SlotW-1:0]      cur_q, cur_d;        // preempted slot
  logic [PartFieldW-1:0] cur_part_q, cur_part_d;
  logic [PARTITIONS-1:0] map_q, map_d;        // partitions with a suspended slot
  logic [PartW-1:0]      part_q, part_d;      // partition walk pointer / chosen
  logic [SlotW-1:0]      next_q, next_d;      // chosen slot
  logic [PartFieldW-1:0] req_part_q, req_part_d;
  logic [KillCountW-1:0] kill_cnt_q, kill_cnt_d;
  logic [PartW-1:0]      last_q, last_d;
  // Cursor holds the slot where the next walk in that partition starts,
  // i.e. one past the last slot chosen there (slot 0 when never scheduled).
  logic [SlotW-1:0]      cursor_q [PARTITIONS];
  logic [SlotW-1:0]      cursor_d [PARTITIONS];

  // pending result, then output register
  logic                  res_had_q, res_had_d;
  logic                  res_sw_q, res_sw_d;
  logic [SlotW-1:0]      res_run_q, res_run_d;
  logic [KillCountW-1:0] res_kill_q, res_kill_d;

  logic                  out_valid_q, out_valid_d;
  logic                  out_had_q, out_had_d;
  logic                  out_sw_q, out_sw_d;
  logic [SlotFieldW-1:0] out_run_q, out_run_d;
  logic [KillCountW-1:0] out_kill_q, out_kill_d;

  // table and compare unit hookup
  slot_entry_t           rd_entry;
  logic                  wr_en;
  logic [SlotW-1:0]      wr_idx;
  slot_entry_t           wr_entry;
  logic [PartFieldW-1:0] target_part;
  match_t                match;
  logic [SlotW-1:0]      step_idx;

  logic                  in_accept;
  logic                  part_paused;
  logic                  entry_part_ok;
  logic                  cur_found_now;
  logic [SlotW-1:0]      cur_now;
  logic [PartFieldW-1:0] cur_part_now;
  logic [PartW-1:0]      part_inc;
  logic [PartW-1:0]      last_inc;

  pfrr_slot_table #(.SLOTS(SLOTS)) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_idx_i   (idx_q),
    .rd_entry_o (rd_entry),
    .wr_en_i    (wr_en),
    .wr_idx_i   (wr_idx),
    .wr_entry_i (wr_entry)
  );

  pfrr_match_unit #(.SLOTS(SLOTS)) u_match (
    .entry_i       (rd_entry),
    .target_part_i (target_part),
    .idx_i         (idx_q),
    .exclude_idx_i (cur_q),
    .match_o       (match),
    .step_idx_o    (step_idx)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // Kill compares against the requested partition, the slot walk against
  // the chosen one. A chosen partition always fits the 3-bit slot field,
  // since only slot partitions ever set its map bit.
  assign target_part = (state_q == S_KILL) ? req_part_q : PartFieldW'(part_q);

  // partitions at 8 and above have no pause bit
  assign part_paused   = (32'(part_q) < 8) && pause_q[PartFieldW'(part_q)];
  assign entry_part_ok = (32'(rd_entry.part) < PARTITIONS);

  assign part_inc = (part_q == PartW'(PARTITIONS - 1)) ? '0 : part_q + PartW'(1);
  assign last_inc = (last_q == PartW'(PARTITIONS - 1)) ? '0 : last_q + PartW'(1);

  // lowest running slot, including the one under the pointer this cycle
  always_comb begin
    cur_found_now = cur_found_q;
    cur_now       = cur_q;
    cur_part_now  = cur_part_q;
    if (!cur_found_q && match.running) begin
      cur_found_now = 1'b1;
      cur_now       = idx_q;
      cur_part_now  = rd_entry.part;
    end
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    cur_found_d = cur_found_q;
    cur_d       = cur_q;
    cur_part_d  = cur_part_q;
    map_d       = map_q;
    part_d      = part_q;
    next_d      = next_q;
    req_part_d  = req_part_q;
    kill_cnt_d  = kill_cnt_q;
    last_d      = last_q;
    cursor_d    = cursor_q;
    res_had_d   = res_had_q;
    res_sw_d    = res_sw_q;
    res_run_d   = res_run_q;
    res_kill_d  = res_kill_q;
    wr_en       = 1'b0;
    wr_idx      = idx_q;
    wr_entry    = rd_entry;

    out_valid_d = out_valid_q && out_stall_i;
    out_had_d   = out_had_q;
    out_sw_d    = out_sw_q;
    out_run_d   = out_run_q;
    out_kill_d  = out_kill_q;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          res_had_d   = 1'b0;
          res_sw_d    = 1'b0;
          res_run_d   = '0;
          res_kill_d  = '0;
          idx_d       = '0;
          cnt_d       = '0;
          cur_found_d = 1'b0;
          map_d       = '0;
          kill_cnt_d  = '0;
          req_part_d  = partition_i;
          case (req_e'(req_type_i))
            REQ_TICK:  state_d = S_SCAN_RUN;
            REQ_KILL:  state_d = S_KILL;
            REQ_WRITE: begin
              // writes beyond the table are dropped
              wr_en    = (32'(slot_index_i) < SLOTS);
              wr_idx   = SlotW'(slot_index_i);
              wr_entry = '{status: slot_status_e'(slot_status_i), part: partition_i};
              state_d  = S_DONE;
            end
            default:   state_d = S_DONE;
          endcase
        end
      end

      S_SCAN_RUN: begin
        cur_found_d = cur_found_now;
        cur_d       = cur_now;
        cur_part_d  = cur_part_now;
        if (match.suspended && entry_part_ok) begin
          map_d[PartW'(rd_entry.part)] = 1'b1;
        end
        idx_d = step_idx;
        if (idx_q == SlotW'(SLOTS - 1)) begin
          if (!cur_found_now) begin
            state_d = S_DONE;                   // nothing to preempt
          end else begin
            // the preempted slot counts as suspended for the partition pick
            if (32'(cur_part_now) < PARTITIONS) begin
              map_d[PartW'(cur_part_now)] = 1'b1;
            end
            part_d  = last_inc;
            cnt_d   = '0;
            state_d = S_PICK_PART;
          end
        end
      end

      S_PICK_PART: begin
        if (map_q[part_q] && !part_paused) begin
          idx_d   = cursor_q[part_q];
          cnt_d   = '0;
          state_d = S_SCAN_SLOT;
        end else if (cnt_q == CntW'(PARTITIONS - 1)) begin
          res_had_d = 1'b1;                     // resume the preempted slot
          res_run_d = cur_q;
          state_d   = S_DONE;
        end else begin
          part_d = part_inc;
          cnt_d  = cnt_q + CntW'(1);
        end
      end

      S_SCAN_SLOT: begin
        if (match.candidate) begin
          next_d           = idx_q;
          cursor_d[part_q] = step_idx;
          last_d           = part_q;
          state_d          = S_SWAP_CUR;
        end else if (cnt_q == CntW'(SLOTS - 1)) begin
          res_had_d = 1'b1;                     // only the preempted slot was eligible
          res_run_d = cur_q;
          state_d   = S_DONE;
        end else begin
          idx_d = step_idx;
          cnt_d = cnt_q + CntW'(1);
        end
      end

      S_SWAP_CUR: begin
        wr_en    = 1'b1;
        wr_idx   = cur_q;
        wr_entry = '{status: ST_SUSPENDED, part: cur_part_q};
        state_d  = S_SWAP_NEXT;
      end

      S_SWAP_NEXT: begin
        wr_en     = 1'b1;
        wr_idx    = next_q;
        wr_entry  = '{status: ST_RUNNING, part: PartFieldW'(part_q)};
        res_had_d = 1'b1;
        res_sw_d  = 1'b1;
        res_run_d = next_q;
        state_d   = S_DONE;
      end

      S_KILL: begin
        if (match.occupied && match.part_eq) begin
          wr_en    = 1'b1;
          wr_entry = '{status: ST_FREE, part: rd_entry.part};
          if (kill_cnt_q != '1) begin
            kill_cnt_d = kill_cnt_q + KillCountW'(1);
          end
        end
        idx_d = step_idx;
        if (idx_q == SlotW'(SLOTS - 1)) begin
          res_kill_d = kill_cnt_d;
          state_d    = S_DONE;
        end
      end

      S_DONE: begin
        // wait here only while the previous result is still held downstream
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_had_d   = res_had_q;
          out_sw_d    = res_sw_q;
          out_run_d   = SlotFieldW'(res_run_q);
          out_kill_d  = res_kill_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pause_q     <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
      for (int p = 0; p < PARTITIONS; p++) begin
        cursor_q[p] <= '0;
      end
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
      cursor_q    <= cursor_d;
      if (cfg_we_i) begin
        pause_q <= cfg_wdata_i;
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    cnt_q       <= cnt_d;
    cur_found_q <= cur_found_d;
    cur_q       <= cur_d;
    cur_part_q  <= cur_part_d;
    map_q       <= map_d;
    part_q      <= part_d;
    next_q      <= next_d;
    req_part_q  <= req_part_d;
    kill_cnt_q  <= kill_cnt_d;
    res_had_q   <= res_had_d;
    res_sw_q    <= res_sw_d;
    res_run_q   <= res_run_d;
    res_kill_q  <= res_kill_d;
    out_had_q   <= out_had_d;
    out_sw_q    <= out_sw_d;
    out_run_q   <= out_run_d;
    out_kill_q  <= out_kill_d;
  end

  assign out_valid_o    = out_valid_q;
  assign had_current_o  = out_had_q;
  assign switched_o     = out_sw_q;
  assign running_slot_o = out_run_q;
  assign killed_count_o = out_kill_q;

endmodule

// ===== dv/partition_fair_round_robin_scheduler_unit_test.sv =====
// ----------------------------------------------------------------------------
// partition_fair_round_robin_scheduler_unit_test
// Drives ticks, slot writes, kills and unknown requests into the scheduler
// and checks each result against an in-bench model of the two-level rotation.
// ----------------------------------------------------------------------------
module partition_fair_round_robin_scheduler_unit_test;
  import pfrr_pkg::*;

  localparam int NSLOT       = 16;
  localparam int NPART       = 8;
  localparam int LIMIT       = 600000;  // watchdog, in clock cycles
  localparam int HOLD_CYCLES = 300;     // long receiver hold-off
  localparam int DRAIN_WAIT  = 50;

  // Request code with no meaning to the block; must come back all zeros.
  localparam logic [ReqW-1:0] REQ_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [ReqW-1:0]       req;
    logic [SlotFieldW-1:0] idx;
    logic [StatusW-1:0]    status;
    logic [PartFieldW-1:0] part;
  } sched_req_t;

  typedef struct packed {
    logic                  had;
    logic                  sw;
    logic [SlotFieldW-1:0] run;
    logic [KillCountW-1:0] killed;
  } sched_result_t;

  // ---------------------------------------------------------------- signals
  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  cfg_we      = 1'b0;
  logic [PauseW-1:0]     cfg_wdata   = '0;
  logic                  in_valid    = 1'b0;
  logic [ReqW-1:0]       req_type    = '0;
  logic [SlotFieldW-1:0] slot_index  = '0;
  logic [StatusW-1:0]    slot_status = '0;
  logic [PartFieldW-1:0] partition   = '0;
  logic                  out_stall   = 1'b0;
  logic                  in_stall;
  logic                  out_valid;
  logic                  had_current;
  logic                  switched;
  logic [SlotFieldW-1:0] running_slot;
  logic [KillCountW-1:0] killed_count;

  partition_fair_round_robin_scheduler_unit #(
    .SLOTS      (NSLOT),
    .PARTITIONS (NPART)
  ) i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .req_type_i     (req_type),
    .slot_index_i   (slot_index),
    .slot_status_i  (slot_status),
    .partition_i    (partition),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .had_current_o  (had_current),
    .switched_o     (switched),
    .running_slot_o (running_slot),
    .killed_count_o (killed_count)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------- scheduler model
  // Own copy of the slot table, cursors and pause mask; advanced once per
  // accepted item, in acceptance order.
  slot_status_e          slot_st [NSLOT];
  logic [PartFieldW-1:0] slot_pt [NSLOT];
  int                    part_cur [NPART];   // -1: partition never scheduled
  int                    last_pt;
  logic [PauseW-1:0]     pause_bits;

  sched_result_t pending_results [$];

  int mismatch_cnt = 0;
  int results_seen = 0;
  int n_ticks = 0, n_switches = 0, n_resumes = 0, n_writes = 0, n_kills = 0;
  int max_killed = 0;
  int cycle_cnt = 0;

  // Receiver hold-off handshake: the test bumps the request count, the stall
  // process serves it and counts the hold down itself.
  int hold_requests = 0;
  int holds_served  = 0;

  function automatic sched_result_t predict_sched_result(sched_req_t it);
    sched_result_t r;
    int cur, next_slot, cand, idx, i, s;
    logic found_part, has_susp;
    int chosen;
    r = '0;
    cur = -1;
    next_slot = -1;
    found_part = 1'b0;
    chosen = 0;
    case (it.req)
      REQ_TICK: begin
        for (i = 0; i < NSLOT; i++) begin
          if (cur < 0 && slot_st[i] == ST_RUNNING) cur = i;
        end
        if (cur >= 0) begin
          r.had = 1'b1;
          // Preempted slot is suspended before the partition search, so its
          // own partition can win the search.
          slot_st[cur] = ST_SUSPENDED;
          for (s = 1; s <= NPART; s++) begin
            cand = (last_pt + s) % NPART;
            has_susp = 1'b0;
            for (i = 0; i < NSLOT; i++) begin
              if (slot_st[i] == ST_SUSPENDED && slot_pt[i] == cand) has_susp = 1'b1;
            end
            if (!found_part && !pause_bits[cand] && has_susp) begin
              found_part = 1'b1;
              chosen = cand;
            end
          end
          if (found_part) begin
            for (s = 1; s <= NSLOT; s++) begin
              idx = (part_cur[chosen] + s) % NSLOT;
              if (next_slot < 0 && idx != cur && slot_st[idx] == ST_SUSPENDED &&
                  slot_pt[idx] == chosen) next_slot = idx;
            end
            if (next_slot >= 0) begin
              part_cur[chosen] = next_slot;
              last_pt = chosen;
            end
          end
          if (next_slot >= 0) begin
            slot_st[next_slot] = ST_RUNNING;
            r.sw  = 1'b1;
            r.run = SlotFieldW'(next_slot);
          end else begin
            // nothing else eligible: preempted slot resumes
            slot_st[cur] = ST_RUNNING;
            r.run = SlotFieldW'(cur);
          end
        end
      end
      REQ_WRITE: begin
        slot_st[it.idx] = slot_status_e'(it.status);
        slot_pt[it.idx] = it.part;
      end
      REQ_KILL: begin
        for (i = 0; i < NSLOT; i++) begin
          if (slot_st[i] != ST_FREE && slot_pt[i] == it.part) begin
            slot_st[i] = ST_FREE;
            if (r.killed != 5'd31) r.killed = r.killed + 5'd1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic sched_req_t make_req(logic [ReqW-1:0] req, int idx,
                                          int status, int part);
    sched_req_t it;
    it.req    = req;
    it.idx    = SlotFieldW'(idx);
    it.status = StatusW'(status);
    it.part   = PartFieldW'(part);
    return it;
  endfunction

  // --------------------------------------------------------------- driving
  // All tasks are entered right after a rising edge and drive with NBAs.
  task automatic send_req(input sched_req_t it);
    sched_result_t r;
    in_valid    <= 1'b1;
    req_type    <= it.req;
    slot_index  <= it.idx;
    slot_status <= it.status;
    partition   <= it.part;
    do @(posedge clk); while (in_stall);
    r = predict_sched_result(it);
    pending_results.push_back(r);
    case (it.req)
      REQ_TICK: begin
        n_ticks++;
        if (r.sw) n_switches++;
        else if (r.had) n_resumes++;
      end
      REQ_WRITE: n_writes++;
      REQ_KILL: begin
        n_kills++;
        if (r.killed > max_killed) max_killed = r.killed;
      end
      default: ;
    endcase
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Every item returns one result, so an empty queue means the block is idle.
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_pause(input logic [PauseW-1:0] mask);
    wait_drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= mask;
    @(posedge clk);
    cfg_we     <= 1'b0;
    pause_bits = mask;
  endtask

  // Fill the whole table with live slots of one partition, then kill it.
  task automatic flood_and_kill(input int part);
    for (int i = 0; i < NSLOT; i++) begin
      send_req(make_req(REQ_WRITE, i, $urandom_range(1, 3), part));
    end
    send_req(make_req(REQ_KILL, 0, 0, part));
  endtask

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ERROR %s: got %0d, want %0d", $time, what, got, want);
    mismatch_cnt++;
  endtask

  always @(posedge clk) begin
    sched_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending", 0, 0);
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        if (had_current !== want.had)
          report_mismatch("had_current", had_current, want.had);
        if (switched !== want.sw)
          report_mismatch("switched", switched, want.sw);
        if (running_slot !== want.run)
          report_mismatch("running_slot", running_slot, want.run);
        if (killed_count !== want.killed)
          report_mismatch("killed_count", killed_count, want.killed);
      end
    end
  end

  // --------------------------------------------------------------- receiver
  // Stall pattern, redrawn as stall_tick runs: none, light random, heavy random,
  // or a fixed 4-of-9 duty. A pending hold request overrides all of them.
  int stall_tick = 0;
  int stall_mode = 0;
  int hold_left  = 0;

  always @(posedge clk) begin
    stall_tick++;
    if (stall_tick % 50 == 0) stall_mode = $urandom_range(0, 3);
    if (hold_left == 0 && holds_served != hold_requests) begin
      holds_served++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ((stall_tick % 9) < 4);
      endcase
    end
  end

  // --------------------------------------------------------------- watchdog
  always @(posedge clk) cycle_cnt++;

  initial begin
    wait (cycle_cnt >= LIMIT);
    $display("Timeout after %0d cycles, %0d results pending", cycle_cnt,
             pending_results.size());
    $display("Simulation FAILED");
    $finish;
  end

  // ------------------------------------------------------------------ tests
  // Empty table tick and an unknown request with every field at its top.
  task automatic test_idle_requests();
    send_req(make_req(REQ_TICK, 0, 0, 0));
    send_req(make_req(REQ_UNKNOWN, NSLOT - 1, ST_ENTRY_PENDING, NPART - 1));
    wait_drain();
  endtask

  // Partition rotation from the last partition, then slot rotation from the
  // partition cursor; pending-entry slots are never candidates.
  task automatic test_rotation();
    send_req(make_req(REQ_WRITE, 0, ST_RUNNING, 0));
    send_req(make_req(REQ_WRITE, 15, ST_SUSPENDED, 7));
    send_req(make_req(REQ_WRITE, 5, ST_SUSPENDED, 0));
    send_req(make_req(REQ_WRITE, 10, ST_ENTRY_PENDING, 7));
    repeat (4) send_req(make_req(REQ_TICK, 0, 0, 0));
    wait_drain();
  endtask

  // Preempted slot wins its own partition search and resumes although another
  // partition holds a suspended slot; kills leave cursors untouched.
  task automatic test_preempt_resume();
    send_req(make_req(REQ_KILL, 0, 0, 0));
    send_req(make_req(REQ_TICK, 0, 0, 0));
    send_req(make_req(REQ_WRITE, 3, ST_RUNNING, 2));
    send_req(make_req(REQ_TICK, 0, 0, 0));
    send_req(make_req(REQ_KILL, 0, 0, 4));
    wait_drain();
  endtask

  // Everything paused: the preempted slot must resume.
  task automatic test_pause_all();
    set_pause(8'hFF);
    send_req(make_req(REQ_TICK, 0, 0, 0));
    send_req(make_req(REQ_TICK, 0, 0, 0));
    wait_drain();
  endtask

  // Random traffic biased toward a few hot partitions, with a running slot
  // kept present most of the time so ticks do real scheduling.
  function automatic sched_req_t rand_req(int hot0, int hot1, int hot2);
    int roll, sr, part, i;
    logic any_run;
    logic [StatusW-1:0] st;
    any_run = 1'b0;
    for (i = 0; i < NSLOT; i++) if (slot_st[i] == ST_RUNNING) any_run = 1'b1;
    case ($urandom_range(0, 3))
      0:       part = $urandom_range(0, NPART - 1);
      1:       part = hot0;
      2:       part = hot1;
      default: part = hot2;
    endcase
    roll = $urandom_range(0, 99);
    if (!any_run && roll < 50)
      return make_req(REQ_WRITE, $urandom_range(0, NSLOT - 1), ST_RUNNING, part);
    if (roll < 45) return make_req(REQ_TICK, $urandom, $urandom, $urandom);
    if (roll < 88) begin
      sr = $urandom_range(0, 9);
      if (sr < 2)      st = ST_FREE;
      else if (sr < 4) st = ST_RUNNING;
      else if (sr < 8) st = ST_SUSPENDED;
      else             st = ST_ENTRY_PENDING;
      return make_req(REQ_WRITE, $urandom_range(0, NSLOT - 1), st, part);
    end
    if (roll < 95) return make_req(REQ_KILL, $urandom, $urandom, part);
    return make_req(REQ_UNKNOWN, $urandom, $urandom, $urandom);
  endfunction

  task automatic test_random_phases();
    logic [PauseW-1:0] masks [6];
    int sent, blen, gap_max, hot0, hot1, hot2;
    masks = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h00, 8'h00};
    masks[4] = PauseW'($urandom);
    masks[5] = PauseW'($urandom);
    for (int ph = 0; ph < 6; ph++) begin
      set_pause(masks[ph]);
      hot0 = $urandom_range(0, NPART - 1);
      hot1 = $urandom_range(0, NPART - 1);
      hot2 = $urandom_range(0, NPART - 1);
      gap_max = (ph == 3) ? 0 : 12;   // one phase with a sender that never idles
      sent = 0;
      if (ph == 2) begin
        // Long receiver hold while the sender keeps offering back to back.
        hold_requests++;
        for (int k = 0; k < 40; k++) send_req(rand_req(hot0, hot1, hot2));
        sent = 40;
      end
      flood_and_kill($urandom_range(0, NPART - 1));
      while (sent < 175) begin
        blen = $urandom_range(1, 16);
        for (int k = 0; k < blen && sent < 175; k++) begin
          send_req(rand_req(hot0, hot1, hot2));
          sent++;
        end
        pause_sender($urandom_range(0, gap_max));
      end
    end
    wait_drain();
  endtask

  // ------------------------------------------------------------------- main
  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      slot_st[i] = ST_FREE;
      slot_pt[i] = '0;
    end
    for (int p = 0; p < NPART; p++) part_cur[p] = -1;
    last_pt    = 0;
    pause_bits = '0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_requests();
    test_rotation();
    test_preempt_resume();
    test_pause_all();
    test_random_phases();

    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Checked %0d results: %0d ticks (%0d switches, %0d resumes), %0d writes,",
             results_seen, n_ticks, n_switches, n_resumes, n_writes);
    $display("%0d kills (largest %0d freed), pause masks from 0x00 to 0xFF, %0d errors",
             n_kills, max_killed, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
